>>> hdl/kvlp_pkg.sv
`default_nettype none
package kvlp_pkg;

   // characters with a meaning in the text
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_EQUALS = 8'h3D;

   // controller states, one-hot
   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } kvlp_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;      // input transaction taken this cycle
      logic start_drain; // snapshot lengths and start reading the pair
      logic issue;       // issue one store read
   } kvlp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic drain_req;   // current byte is a newline that closes a complete pair
      logic can_issue;   // read slot free for another character
      logic last_read;   // next read is the final character of the pair
   } kvlp_status_type;

endpackage
`default_nettype wire

>>> hdl/kvlp_ram.sv
`default_nettype none
module kvlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port; read data holds without rd_en
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/kvlp_ctrl.sv
`default_nettype none
module kvlp_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire kvlp_pkg::kvlp_status_type status,
   output kvlp_pkg::kvlp_cmd_type         cmd
);
   import kvlp_pkg::*;

   kvlp_state_type state_ff;
   kvlp_state_type state_in;

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd.accept      = 1'b0;
      cmd.start_drain = 1'b0;
      cmd.issue       = 1'b0;
      req_tready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.drain_req) begin
                  cmd.start_drain = 1'b1;
                  state_in        = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (status.can_issue) begin
               cmd.issue = 1'b1;
               if (status.last_read) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // reads are only issued while draining
   a_issue_in_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> state_ff == ST_DRAIN)
      else $error("read issued outside drain");

   // a drain always starts from a taken newline
   a_drain_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && state_in == ST_DRAIN) |-> cmd.accept && status.drain_req)
      else $error("drain entered without a closing newline");

   // the final read hands control back for the next byte
   a_drain_exit: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && status.last_read) |=> state_ff == ST_IDLE)
      else $error("drain did not end after the final read");
`endif

endmodule
`default_nettype wire

>>> hdl/kvlp_dp.sv
`default_nettype none
module kvlp_dp #(
   parameter int KEY_CHARS   = 16,
   parameter int VALUE_CHARS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             req_tdata,
   input  wire kvlp_pkg::kvlp_cmd_type cmd,
   output kvlp_pkg::kvlp_status_type   status,
   input  wire logic                   rsp_tready,
   output logic                        rsp_tvalid,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);
   import kvlp_pkg::*;

   localparam int MAXC = (KEY_CHARS > VALUE_CHARS) ? KEY_CHARS : VALUE_CHARS;
   localparam int LW   = $clog2(MAXC + 1);
   localparam int KAW  = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
   localparam int VAW  = (VALUE_CHARS > 1) ? $clog2(VALUE_CHARS) : 1;

   // line state
   logic [LW-1:0] key_len_ff, key_len_in;
   logic [LW-1:0] val_len_ff, val_len_in;
   logic          comment_ff, comment_in;
   logic          vphase_ff, vphase_in;

   // drain state
   logic [LW-1:0] drn_key_ff, drn_key_in;
   logic [LW-1:0] drn_val_ff, drn_val_in;
   logic [LW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_vsel_ff, rd_vsel_in;

   // read data waiting for the output register
   logic pend_ff, pend_in;
   logic pend_vsel_ff, pend_vsel_in;
   logic pend_last_ff, pend_last_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_isval_ff, out_isval_in;
   logic       out_last_ff, out_last_in;

   logic       key_wr, val_wr, key_rd, val_rd;
   logic [7:0] key_q, val_q;
   logic       load;
   logic       is_sep;

   assign is_sep = (req_tdata == CH_SPACE) || (req_tdata == CH_EQUALS);

   // key and value stores
   kvlp_ram #(.WIDTH(8), .DEPTH(KEY_CHARS), .AW(KAW)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr),
      .wr_addr (key_len_ff[KAW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (key_rd),
      .rd_addr (rd_idx_ff[KAW-1:0]),
      .rd_data (key_q)
   );

   kvlp_ram #(.WIDTH(8), .DEPTH(VALUE_CHARS), .AW(VAW)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr),
      .wr_addr (val_len_ff[VAW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (val_rd),
      .rd_addr (rd_idx_ff[VAW-1:0]),
      .rd_data (val_q)
   );

   // status toward the controller
   assign load             = pend_ff && (!out_valid_ff || rsp_tready);
   assign status.can_issue = !pend_ff || load;
   assign status.drain_req = (req_tdata == CH_LF) && vphase_ff &&
                             (key_len_ff != '0) && (val_len_ff != '0);
   assign status.last_read = rd_vsel_ff && (rd_idx_ff + LW'(1) == drn_val_ff);

   // byte parsing
   always_comb begin
      key_len_in = key_len_ff;
      val_len_in = val_len_ff;
      comment_in = comment_ff;
      vphase_in  = vphase_ff;
      key_wr     = 1'b0;
      val_wr     = 1'b0;
      if (cmd.accept && req_tdata != CH_TAB && req_tdata != CH_CR) begin
         if (req_tdata == CH_LF) begin
            key_len_in = '0;
            val_len_in = '0;
            comment_in = 1'b0;
            vphase_in  = 1'b0;
         end else if (!comment_ff) begin
            if (!vphase_ff) begin
               if (key_len_ff == '0 && req_tdata == CH_HASH) begin
                  comment_in = 1'b1;
               end else if (is_sep) begin
                  vphase_in = 1'b1;
               end else if (key_len_ff < LW'(KEY_CHARS)) begin
                  key_wr     = 1'b1;
                  key_len_in = key_len_ff + LW'(1);
               end
            end else if (!(val_len_ff == '0 && is_sep)) begin
               if (val_len_ff < LW'(VALUE_CHARS)) begin
                  val_wr     = 1'b1;
                  val_len_in = val_len_ff + LW'(1);
               end
            end
         end
      end
   end

   // drain sequencing: key characters first, then value characters
   always_comb begin
      drn_key_in   = drn_key_ff;
      drn_val_in   = drn_val_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vsel_in   = rd_vsel_ff;
      key_rd       = 1'b0;
      val_rd       = 1'b0;
      pend_in      = pend_ff && !load;
      pend_vsel_in = pend_vsel_ff;
      pend_last_in = pend_last_ff;
      if (cmd.start_drain) begin
         drn_key_in = key_len_ff;
         drn_val_in = val_len_ff;
         rd_idx_in  = '0;
         rd_vsel_in = 1'b0;
      end else if (cmd.issue) begin
         pend_in      = 1'b1;
         pend_vsel_in = rd_vsel_ff;
         pend_last_in = status.last_read;
         if (!rd_vsel_ff) begin
            key_rd = 1'b1;
            if (rd_idx_ff + LW'(1) == drn_key_ff) begin
               rd_idx_in  = '0;
               rd_vsel_in = 1'b1;
            end else begin
               rd_idx_in = rd_idx_ff + LW'(1);
            end
         end else begin
            val_rd    = 1'b1;
            rd_idx_in = rd_idx_ff + LW'(1);
         end
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_isval_in = out_isval_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_char_in  = pend_vsel_ff ? val_q : key_q;
         out_isval_in = pend_vsel_ff;
         out_last_in  = pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff   <= '0;
         val_len_ff   <= '0;
         comment_ff   <= 1'b0;
         vphase_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         rd_vsel_ff   <= 1'b0;
      end else begin
         key_len_ff   <= key_len_in;
         val_len_ff   <= val_len_in;
         comment_ff   <= comment_in;
         vphase_ff    <= vphase_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         rd_vsel_ff   <= rd_vsel_in;
      end
   end

   always_ff @(posedge clock) begin
      drn_key_ff   <= drn_key_in;
      drn_val_ff   <= drn_val_in;
      rd_idx_ff    <= rd_idx_in;
      pend_vsel_ff <= pend_vsel_in;
      pend_last_ff <= pend_last_in;
      out_char_ff  <= out_char_in;
      out_isval_ff <= out_isval_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tuser  = out_isval_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   // a read never overwrites data still waiting for the output register
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (!pend_ff || load))
      else $error("store read overran pending data");

   // only a value character closes the pair
   a_last_is_value: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> out_isval_ff)
      else $error("last set on a key character");

   // lengths saturate at the store capacity
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (key_len_ff <= LW'(KEY_CHARS)) && (val_len_ff <= LW'(VALUE_CHARS)))
      else $error("line length beyond capacity");
`endif

endmodule
`default_nettype wire

>>> hdl/key_value_line_parser_core.sv
// input: one byte per cycle between newlines; a closing newline snapshots the lengths, then the key and value
//   stores are read into the output register, one character per cycle while rsp_tready holds
// flow: a newline that emits a pair keeps req_tready low until the final character of the pair has been
//   read from the stores, longer while rsp_tready is low
// reset: synchronous, active high; clears line state and output valid, stores keep contents
`default_nettype none
module key_value_line_parser_core #(
   parameter int KEY_CHARS   = 16,
   parameter int VALUE_CHARS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // input byte stream
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_char
   // emitted key/value characters
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_char
   output logic            rsp_tuser,   // [0] is_value
   output logic            rsp_tlast
);
   import kvlp_pkg::*;

   kvlp_cmd_type    cmd;
   kvlp_status_type status;

   // sequencer
   kvlp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // parsing, stores and output register
   kvlp_dp #(
      .KEY_CHARS   (KEY_CHARS),
      .VALUE_CHARS (VALUE_CHARS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> tb/sv/key_value_line_parser_core_tb.sv
`timescale 1ns / 1ps
module key_value_line_parser_core_tb;
   import kvlp_pkg::*;

   localparam int KEY_CAP = 16;
   localparam int VAL_CAP = 32;

   // one emitted character as seen on the result stream
   typedef struct {
      logic [7:0] ch;
      logic       is_value;
      logic       last;
   } kv_char_type;

   typedef logic [7:0] byte_q_type[$];

   // line predictor plus the queue of characters still to come out
   class pair_scoreboard;
      kv_char_type pending_chars[$];
      logic [7:0]  key_buf[KEY_CAP];
      logic [7:0]  val_buf[VAL_CAP];
      int          key_len;
      int          val_len;
      bit          comment_line;
      bit          value_phase;
      int          errors;

      function new();
         key_len      = 0;
         val_len      = 0;
         comment_line = 1'b0;
         value_phase  = 1'b0;
         errors       = 0;
      endfunction

      task report(input string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function int pending();
         return pending_chars.size();
      endfunction

      // advance the line state by one accepted byte
      function void note_byte(input logic [7:0] c);
         kv_char_type e;
         if (c == CH_TAB || c == CH_CR) return;
         if (c == CH_LF) begin
            // a complete pair drains key then value
            if (value_phase && key_len > 0 && val_len > 0) begin
               for (int k = 0; k < key_len; k++) begin
                  e.ch       = key_buf[k];
                  e.is_value = 1'b0;
                  e.last     = 1'b0;
                  pending_chars.push_back(e);
               end
               for (int k = 0; k < val_len; k++) begin
                  e.ch       = val_buf[k];
                  e.is_value = 1'b1;
                  e.last     = (k == val_len - 1);
                  pending_chars.push_back(e);
               end
            end
            key_len      = 0;
            val_len      = 0;
            comment_line = 1'b0;
            value_phase  = 1'b0;
         end else if (!comment_line) begin
            if (!value_phase) begin
               if (key_len == 0 && c == CH_HASH) begin
                  comment_line = 1'b1;
               end else if (c == CH_SPACE || c == CH_EQUALS) begin
                  value_phase = 1'b1;
               end else if (key_len < KEY_CAP) begin
                  key_buf[key_len] = c;
                  key_len++;
               end
            end else if (!(val_len == 0 && (c == CH_SPACE || c == CH_EQUALS))) begin
               // leading separators skipped, overflow dropped
               if (val_len < VAL_CAP) begin
                  val_buf[val_len] = c;
                  val_len++;
               end
            end
         end
      endfunction

      // compare one result transaction with the oldest expected character
      task check_char(input logic [7:0] ch, input logic is_value, input logic last);
         kv_char_type e;
         if (pending_chars.size() == 0) begin
            report($sformatf("unexpected character %h user %b last %b", ch, is_value, last));
            return;
         end
         e = pending_chars.pop_front();
         if (ch !== e.ch)
            report($sformatf("out_char %h, predicted %h", ch, e.ch));
         if (is_value !== e.is_value)
            report($sformatf("is_value %b, predicted %b (char %h)", is_value, e.is_value, e.ch));
         if (last !== e.last)
            report($sformatf("last %b, predicted %b (char %h)", last, e.last, e.ch));
      endtask
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   pair_scoreboard sb = new();

   bit no_idle       = 1'b0;
   int hold_requests = 0;
   int bytes_sent    = 0;

   always #5 clock = ~clock;

   key_value_line_parser_core #(
      .KEY_CHARS  (KEY_CAP),
      .VALUE_CHARS(VAL_CAP)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // offer one byte, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      while (!no_idle && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   // send a line, optionally sprinkled with ignored tab and carriage return
   task automatic send_text(input byte_q_type t, input bit noisy);
      foreach (t[i]) begin
         if (noisy && $urandom_range(19) == 0)
            send_byte($urandom_range(1) ? CH_TAB : CH_CR);
         send_byte(t[i]);
      end
   endtask

   // mostly well-formed pairs, some flawed ones, comments and raw noise
   task automatic random_line();
      byte_q_type t;
      int         mode;
      int         flaw;
      int         klen;
      int         vlen;
      int         n;
      logic [7:0] c;
      mode = $urandom_range(99);
      if (mode < 65) begin
         flaw = $urandom_range(9);
         klen = ($urandom_range(9) == 0) ? $urandom_range(KEY_CAP + 1, KEY_CAP + 4)
                                         : $urandom_range(1, 6);
         vlen = ($urandom_range(9) == 0) ? $urandom_range(VAL_CAP + 1, VAL_CAP + 4)
                                         : $urandom_range(1, 8);
         if (flaw != 0) begin
            for (int i = 0; i < klen; i++) begin
               do c = 8'($urandom_range(255));
               while (c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_SPACE ||
                      c == CH_EQUALS || (i == 0 && c == CH_HASH));
               t.push_back(c);
            end
         end
         if (flaw != 1) begin
            n = $urandom_range(2);
            for (int i = 0; i <= n; i++)
               t.push_back($urandom_range(1) ? CH_SPACE : CH_EQUALS);
         end
         if (flaw != 2) begin
            for (int i = 0; i < vlen; i++) begin
               do c = 8'($urandom_range(255));
               while (c == CH_TAB || c == CH_CR || c == CH_LF ||
                      (i == 0 && (c == CH_SPACE || c == CH_EQUALS)));
               t.push_back(c);
            end
         end
      end else if (mode < 80) begin
         t.push_back(CH_HASH);
         n = $urandom_range(8);
         for (int i = 0; i < n; i++) begin
            do c = 8'($urandom_range(255));
            while (c == CH_LF);
            t.push_back(c);
         end
      end else begin
         n = $urandom_range(1, 10);
         for (int i = 0; i < n; i++)
            t.push_back(8'($urandom_range(255)));
      end
      t.push_back(CH_LF);
      send_text(t, 1'b1);
   endtask

   // receiver: check each result transaction and drive back-pressure
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_char(rsp_tdata, rsp_tuser, rsp_tlast);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 35);
         end
      end
   end

   // stimulus and end of run
   initial begin
      int line_no;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, ignored bytes and leading value separators
      send_text('{8'h00, CH_TAB, CH_EQUALS, CH_CR, CH_SPACE, 8'hFF, CH_LF}, 1'b0);
      // comment line
      send_text('{CH_HASH, "a", CH_EQUALS, "b", CH_LF}, 1'b0);
      // hash inside key and as value
      send_text('{"k", CH_HASH, CH_EQUALS, CH_SPACE, CH_HASH, CH_LF}, 1'b0);
      // no separator, empty value, empty key
      send_text('{"a", "b", CH_LF}, 1'b0);
      send_text('{"k", CH_EQUALS, CH_LF}, 1'b0);
      send_text('{CH_EQUALS, "v", CH_LF}, 1'b0);

      line_no = 0;
      while (bytes_sent < 330) begin
         if (line_no == 8) hold_requests++;
         if (line_no == 20) begin
            req_tvalid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end
         no_idle = (line_no >= 30 && line_no < 45);
         random_line();
         line_no++;
      end
      no_idle = 1'b0;

      // trailing text without newline stays pending
      send_text('{"z", "z", CH_EQUALS, "1"}, 1'b0);
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d predicted characters never came out", sb.pending()));
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
